/* design/eftr_pkg.sv */
// Shared types and constants of the edge-function triangle rasterizer.
// No dependencies; every other design file but eftr_queue refers to it by scoped names.
`default_nettype none

package eftr_pkg;

    localparam int VERT_W          = 16;
    localparam int COLOR_W         = 32;
    localparam int PIX_W           = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int SCREEN_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 4;
    localparam int QUEUE_DEPTH     = 4;
    localparam int BACK_STAGES     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERT_A_X   = 3'd0,
        REG_VERT_A_Y   = 3'd1,
        REG_VERT_B_X   = 3'd2,
        REG_VERT_B_Y   = 3'd3,
        REG_VERT_C_X   = 3'd4,
        REG_VERT_C_Y   = 3'd5,
        REG_FILL_COLOR = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [VERT_W-1:0]  vert_a_x;
        logic [VERT_W-1:0]  vert_a_y;
        logic [VERT_W-1:0]  vert_b_x;
        logic [VERT_W-1:0]  vert_b_y;
        logic [VERT_W-1:0]  vert_c_x;
        logic [VERT_W-1:0]  vert_c_y;
        logic [COLOR_W-1:0] fill_color;
    } tri_cfg_t;

endpackage

`default_nettype wire

/* design/eftr_if.sv */
// Channel interfaces of the rasterizer: step requests, pixel results, register writes.
// Depends on eftr_pkg for the payload widths.
`default_nettype none

interface eftr_step_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface eftr_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [eftr_pkg::PIX_W-1:0]   pix_x;
    logic [eftr_pkg::PIX_W-1:0]   pix_y;
    logic                         covered;
    logic [eftr_pkg::COLOR_W-1:0] pix_color;
    logic                         last;

    modport source (output valid, output pix_x, output pix_y, output covered,
                    output pix_color, output last, input ready);
    modport sink   (input valid, input pix_x, input pix_y, input covered,
                    input pix_color, input last, output ready);
endinterface

interface eftr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [eftr_pkg::CFG_IDX_W-1:0]  index;
    logic [eftr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/eftr_walk.sv */
// Front end: bounding box of the triangle and the pixel walk over it.
// Depends on eftr_pkg for the register struct and vertex width.
`default_nettype none

module eftr_walk #(
    parameter int SCREEN_BITS = eftr_pkg::SCREEN_BITS_DEF,
    parameter int FRAC_BITS   = eftr_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  eftr_pkg::tri_cfg_t     tri_cfg,
    input  logic                   step_valid,
    input  logic                   restart,
    output logic                   step_ready,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [SCREEN_BITS-1:0] push_x,
    output logic [SCREEN_BITS-1:0] push_y,
    output logic                   push_last
);

    localparam int VW = eftr_pkg::VERT_W;
    localparam logic [VW:0] LIM = (VW+1)'((1 << SCREEN_BITS) - 1);

    logic [SCREEN_BITS-1:0] walk_x_reg, walk_x_next;
    logic [SCREEN_BITS-1:0] walk_y_reg, walk_y_next;
    logic                   walk_active_reg;
    logic [SCREEN_BITS-1:0] ax, bx, cx, ay, by, cy;
    logic [SCREEN_BITS-1:0] min_x, max_x, min_y, max_y;
    logic [SCREEN_BITS-1:0] mx_ab, nx_ab, my_ab, ny_ab;
    logic                   in_box;
    logic                   accept;

    // Integer part of a vertex, saturated to the screen for the box only.
    function automatic logic [SCREEN_BITS-1:0] int_part(input logic [VW-1:0] v);
        logic [VW-1:0] ip;
        ip = v >> FRAC_BITS;
        if ({1'b0, ip} > LIM)
            return SCREEN_BITS'(LIM);
        else
            return SCREEN_BITS'(ip);
    endfunction

    always_comb
    begin
        ax = int_part(tri_cfg.vert_a_x);
        bx = int_part(tri_cfg.vert_b_x);
        cx = int_part(tri_cfg.vert_c_x);
        ay = int_part(tri_cfg.vert_a_y);
        by = int_part(tri_cfg.vert_b_y);
        cy = int_part(tri_cfg.vert_c_y);
        nx_ab = (ax < bx) ? ax : bx;
        mx_ab = (ax > bx) ? ax : bx;
        ny_ab = (ay < by) ? ay : by;
        my_ab = (ay > by) ? ay : by;
        min_x = (nx_ab < cx) ? nx_ab : cx;
        max_x = (mx_ab > cx) ? mx_ab : cx;
        min_y = (ny_ab < cy) ? ny_ab : cy;
        max_y = (my_ab > cy) ? my_ab : cy;
    end

    assign in_box = (walk_x_reg >= min_x) && (walk_x_reg <= max_x) &&
                    (walk_y_reg >= min_y) && (walk_y_reg <= max_y);

    always_comb
    begin
        priority if (restart || !walk_active_reg || !in_box)
        begin
            walk_x_next = min_x;
            walk_y_next = min_y;
        end
        else if (walk_x_reg >= max_x)
        begin
            walk_x_next = min_x;
            walk_y_next = (walk_y_reg >= max_y) ? min_y : walk_y_reg + 1'b1;
        end
        else
        begin
            walk_x_next = walk_x_reg + 1'b1;
            walk_y_next = walk_y_reg;
        end
    end

    assign accept     = step_valid && push_ready;
    assign step_ready = push_ready;
    assign push_valid = step_valid;
    assign push_x     = walk_x_next;
    assign push_y     = walk_y_next;
    assign push_last  = (walk_x_next == max_x) && (walk_y_next == max_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg      <= '0;
            walk_y_reg      <= '0;
            walk_active_reg <= 1'b0;
        end
        else if (accept)
        begin
            walk_x_reg      <= walk_x_next;
            walk_y_reg      <= walk_y_next;
            walk_active_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

/* design/eftr_queue.sv */
// Small register queue between the walk front end and the edge evaluator.
// Depends on nothing but its parameters.
`default_nettype none

module eftr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* design/eftr_edge.sv */
// Back end: three-stage edge function pipeline ending in the pixel output register.
// Depends on eftr_pkg and on the pixel channel interface.
`default_nettype none

module eftr_edge #(
    parameter int SCREEN_BITS = eftr_pkg::SCREEN_BITS_DEF,
    parameter int FRAC_BITS   = eftr_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  eftr_pkg::tri_cfg_t     tri_cfg,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [SCREEN_BITS-1:0] pop_x,
    input  logic [SCREEN_BITS-1:0] pop_y,
    input  logic                   pop_last,
    eftr_pixel_if.source           pixel
);

    localparam int VW     = eftr_pkg::VERT_W;
    localparam int POS_W  = SCREEN_BITS + FRAC_BITS;
    localparam int DIFF_W = ((POS_W > VW) ? POS_W : VW) + 1;
    localparam int EV_W   = VW + 1;
    localparam int PROD_W = DIFF_W + EV_W;
    localparam int EDGE_W = PROD_W + 1;

    logic advance;

    // Stage 1: pixel corner minus each vertex.
    logic                     s1_valid_reg;
    logic [SCREEN_BITS-1:0]   s1_x_reg, s1_y_reg;
    logic                     s1_last_reg;
    logic signed [DIFF_W-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, dxc_reg, dyc_reg;
    logic [POS_W-1:0]         px, py;

    // Stage 2: the six cross-product terms.
    logic                     s2_valid_reg;
    logic [SCREEN_BITS-1:0]   s2_x_reg, s2_y_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] pab_reg, qab_reg, pbc_reg, qbc_reg, pca_reg, qca_reg;

    // The user must change edge vectors only while the block is idle; the block does not enforce it.
    logic signed [EV_W-1:0]   eab_x, eab_y, ebc_x, ebc_y, eca_x, eca_y;

    logic signed [EDGE_W-1:0] e_ab, e_bc, e_ca;
    logic                     cov;

    logic                     out_valid_reg;
    logic [eftr_pkg::PIX_W-1:0]   pix_x_reg, pix_y_reg;
    logic                     covered_reg, last_reg;
    logic [eftr_pkg::COLOR_W-1:0] color_reg;

    // The whole back end moves together whenever the output register can take a result.
    assign advance   = !out_valid_reg || pixel.ready;
    assign pop_ready = advance;

    assign px = POS_W'(pop_x) << FRAC_BITS;
    assign py = POS_W'(pop_y) << FRAC_BITS;

    assign eab_x = EV_W'(tri_cfg.vert_b_x) - EV_W'(tri_cfg.vert_a_x);
    assign eab_y = EV_W'(tri_cfg.vert_b_y) - EV_W'(tri_cfg.vert_a_y);
    assign ebc_x = EV_W'(tri_cfg.vert_c_x) - EV_W'(tri_cfg.vert_b_x);
    assign ebc_y = EV_W'(tri_cfg.vert_c_y) - EV_W'(tri_cfg.vert_b_y);
    assign eca_x = EV_W'(tri_cfg.vert_a_x) - EV_W'(tri_cfg.vert_c_x);
    assign eca_y = EV_W'(tri_cfg.vert_a_y) - EV_W'(tri_cfg.vert_c_y);

    assign e_ab = EDGE_W'(pab_reg) - EDGE_W'(qab_reg);
    assign e_bc = EDGE_W'(pbc_reg) - EDGE_W'(qbc_reg);
    assign e_ca = EDGE_W'(pca_reg) - EDGE_W'(qca_reg);
    assign cov  = !e_ab[EDGE_W-1] && !e_bc[EDGE_W-1] && !e_ca[EDGE_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg    <= pop_x;
            s1_y_reg    <= pop_y;
            s1_last_reg <= pop_last;
            dxa_reg     <= DIFF_W'(px) - DIFF_W'(tri_cfg.vert_a_x);
            dya_reg     <= DIFF_W'(py) - DIFF_W'(tri_cfg.vert_a_y);
            dxb_reg     <= DIFF_W'(px) - DIFF_W'(tri_cfg.vert_b_x);
            dyb_reg     <= DIFF_W'(py) - DIFF_W'(tri_cfg.vert_b_y);
            dxc_reg     <= DIFF_W'(px) - DIFF_W'(tri_cfg.vert_c_x);
            dyc_reg     <= DIFF_W'(py) - DIFF_W'(tri_cfg.vert_c_y);

            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_last_reg <= s1_last_reg;
            pab_reg     <= eab_x * dya_reg;
            qab_reg     <= eab_y * dxa_reg;
            pbc_reg     <= ebc_x * dyb_reg;
            qbc_reg     <= ebc_y * dxb_reg;
            pca_reg     <= eca_x * dyc_reg;
            qca_reg     <= eca_y * dxc_reg;

            pix_x_reg   <= eftr_pkg::PIX_W'(s2_x_reg);
            pix_y_reg   <= eftr_pkg::PIX_W'(s2_y_reg);
            covered_reg <= cov;
            color_reg   <= cov ? tri_cfg.fill_color : '0;
            last_reg    <= s2_last_reg;
        end
    end

    assign pixel.valid     = out_valid_reg;
    assign pixel.pix_x     = pix_x_reg;
    assign pixel.pix_y     = pix_y_reg;
    assign pixel.covered   = covered_reg;
    assign pixel.pix_color = color_reg;
    assign pixel.last      = last_reg;

endmodule

`default_nettype wire

/* design/edge_function_triangle_raster.sv */
// Top level of the edge-function triangle rasterizer: register file, walk, queue, evaluator.
// Depends on eftr_pkg, the channel interfaces, eftr_walk, eftr_queue and eftr_edge.
//
//   Channel  Dir  Handshake     Carries
//   step     in   valid/ready   restart
//   pixel    out  valid/ready   pix_x, pix_y, covered, pix_color, last
//   cfg      in   valid/ready   index, data (register write)
//
// One pixel per clock is sustained while the pixel output is not stalled; a step request
// passes from the queue to the first evaluator stage, then the second stage, then the
// output register, where it shows up as a valid pixel.
// Reset clears the registers, the walk position and all valid state; no clearing pass.
// A stalled pixel output freezes the evaluator; the four-entry queue keeps taking
// requests until it is full, and the register port is always ready.
`default_nettype none

module edge_function_triangle_raster #(
    parameter int SCREEN_BITS = eftr_pkg::SCREEN_BITS_DEF,
    parameter int FRAC_BITS   = eftr_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    eftr_step_if.sink     step,
    eftr_pixel_if.source  pixel,
    eftr_cfg_if.sink      cfg
);

    localparam int QW = 2 * SCREEN_BITS + 1;
    localparam int VW = eftr_pkg::VERT_W;

    eftr_pkg::tri_cfg_t     tri_cfg_reg;
    logic                   push_valid, push_ready;
    logic [SCREEN_BITS-1:0] push_x, push_y;
    logic                   push_last;
    logic                   pop_valid, pop_ready;
    logic [QW-1:0]          pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (eftr_pkg::cfg_reg_t'(cfg.index))
                eftr_pkg::REG_VERT_A_X:   tri_cfg_reg.vert_a_x   <= cfg.data[VW-1:0];
                eftr_pkg::REG_VERT_A_Y:   tri_cfg_reg.vert_a_y   <= cfg.data[VW-1:0];
                eftr_pkg::REG_VERT_B_X:   tri_cfg_reg.vert_b_x   <= cfg.data[VW-1:0];
                eftr_pkg::REG_VERT_B_Y:   tri_cfg_reg.vert_b_y   <= cfg.data[VW-1:0];
                eftr_pkg::REG_VERT_C_X:   tri_cfg_reg.vert_c_x   <= cfg.data[VW-1:0];
                eftr_pkg::REG_VERT_C_Y:   tri_cfg_reg.vert_c_y   <= cfg.data[VW-1:0];
                eftr_pkg::REG_FILL_COLOR: tri_cfg_reg.fill_color <=
                                              cfg.data[eftr_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    eftr_walk #(
        .SCREEN_BITS (SCREEN_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_cfg    (tri_cfg_reg),
        .step_valid (step.valid),
        .restart    (step.restart),
        .step_ready (step.ready),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_x     (push_x),
        .push_y     (push_y),
        .push_last  (push_last)
    );

    eftr_queue #(
        .WIDTH (QW),
        .DEPTH (eftr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_x, push_y, push_last}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    eftr_edge #(
        .SCREEN_BITS (SCREEN_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_cfg   (tri_cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_x     (pop_data[QW-1 -: SCREEN_BITS]),
        .pop_y     (pop_data[SCREEN_BITS:1]),
        .pop_last  (pop_data[0]),
        .pixel     (pixel)
    );

endmodule

`default_nettype wire

/* design/eftr_checker.sv */
// Port-level checks of the rasterizer, attached to the top level with bind.
// Depends on eftr_pkg for widths and the depth of the request queue.
`default_nettype none

module eftr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         step_valid,
    input logic                         step_ready,
    input logic                         pixel_valid,
    input logic                         pixel_ready,
    input logic [eftr_pkg::PIX_W-1:0]   pix_x,
    input logic [eftr_pkg::PIX_W-1:0]   pix_y,
    input logic                         covered,
    input logic [eftr_pkg::COLOR_W-1:0] pix_color,
    input logic                         last
);

    localparam int MAX_PEND = eftr_pkg::QUEUE_DEPTH + eftr_pkg::BACK_STAGES;
    localparam int PEND_W   = $clog2(MAX_PEND + 2);

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic              step_acc, pixel_acc;

    assign step_acc  = step_valid && step_ready;
    assign pixel_acc = pixel_valid && pixel_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (step_acc && !pixel_acc)
            pending_next = pending_reg + 1'b1;
        else if (pixel_acc && !step_acc)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // Every pixel answers exactly one earlier step request.
    a_no_extra_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> pending_reg != '0)
        else $error("pixel shown with no step request outstanding");

    // The queue and the evaluator stages bound the requests in flight.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(MAX_PEND))
        else $error("more step requests in flight than the block can hold");

    a_uncovered_black: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !covered |-> pix_color == '0)
        else $error("uncovered pixel carries a color");

    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=>
            pixel_valid && $stable({pix_x, pix_y, covered, pix_color, last}))
        else $error("stalled pixel changed or was dropped");

endmodule

bind edge_function_triangle_raster eftr_checker u_eftr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_valid  (step.valid),
    .step_ready  (step.ready),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .pix_x       (pixel.pix_x),
    .pix_y       (pixel.pix_y),
    .covered     (pixel.covered),
    .pix_color   (pixel.pix_color),
    .last        (pixel.last)
);

`default_nettype wire

/* dv/edge_function_triangle_raster_tb.sv */
// Self-checking testbench for the edge-function triangle rasterizer: it walks
// bounding boxes through the step channel and checks every pixel result.
// Depends on eftr_pkg, the channel interfaces and edge_function_triangle_raster.
`timescale 1ns / 1ps

module edge_function_triangle_raster_tb;

    localparam int FRAC_BITS   = eftr_pkg::FRAC_BITS_DEF;
    localparam int SCREEN_MAX  = (1 << eftr_pkg::SCREEN_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PIX_W       = eftr_pkg::PIX_W;
    localparam int COLOR_W     = eftr_pkg::COLOR_W;
    localparam int VERT_W      = eftr_pkg::VERT_W;
    localparam int CFG_DATA_W  = eftr_pkg::CFG_DATA_W;

    typedef struct {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic               covered;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    logic clk;
    logic rst_n;

    eftr_step_if  step_ch();
    eftr_pixel_if pixel_ch();
    eftr_cfg_if   cfg_ch();

    edge_function_triangle_raster u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step_ch),
        .pixel (pixel_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state: register copy and walk position.
    eftr_pkg::tri_cfg_t tri_regs;
    logic [PIX_W-1:0]   walk_x;
    logic [PIX_W-1:0]   walk_y;
    logic               walk_active;

    logic   pending_steps[$];
    pixel_t expected_pixels[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int cycle_count;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_failure(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    function automatic logic [PIX_W-1:0] vert_int(input logic [VERT_W-1:0] v);
        int unsigned i;
        i = 32'(v) >> FRAC_BITS;
        if (i > SCREEN_MAX)
        begin
            i = SCREEN_MAX;
        end
        return i[PIX_W-1:0];
    endfunction

    function automatic void box_span(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] c,
                                     output logic [PIX_W-1:0] lo,
                                     output logic [PIX_W-1:0] hi);
        lo = (a < b) ? a : b;
        lo = (lo < c) ? lo : c;
        hi = (a > b) ? a : b;
        hi = (hi > c) ? hi : c;
    endfunction

    // Cross product of the edge (x0,y0)->(x1,y1) with the offset of (px,py).
    function automatic longint edge_value(input logic [VERT_W-1:0] x0,
                                          input logic [VERT_W-1:0] y0,
                                          input logic [VERT_W-1:0] x1,
                                          input logic [VERT_W-1:0] y1,
                                          input longint px, input longint py);
        return (longint'(x1) - longint'(x0)) * (py - longint'(y0))
             - (longint'(y1) - longint'(y0)) * (px - longint'(x0));
    endfunction

    function automatic pixel_t predict_pixel(input logic restart);
        pixel_t           p;
        logic [PIX_W-1:0] minx, maxx, miny, maxy;
        logic             in_box;
        longint           px, py, e_ab, e_bc, e_ca;
        box_span(vert_int(tri_regs.vert_a_x), vert_int(tri_regs.vert_b_x),
                 vert_int(tri_regs.vert_c_x), minx, maxx);
        box_span(vert_int(tri_regs.vert_a_y), vert_int(tri_regs.vert_b_y),
                 vert_int(tri_regs.vert_c_y), miny, maxy);
        in_box = walk_x >= minx && walk_x <= maxx && walk_y >= miny && walk_y <= maxy;
        if (restart || !walk_active || !in_box)
        begin
            walk_x      = minx;
            walk_y      = miny;
            walk_active = 1'b1;
        end
        else if (walk_x >= maxx)
        begin
            walk_x = minx;
            walk_y = (walk_y >= maxy) ? miny : walk_y + 1'b1;
        end
        else
        begin
            walk_x = walk_x + 1'b1;
        end
        px   = longint'(walk_x) << FRAC_BITS;
        py   = longint'(walk_y) << FRAC_BITS;
        e_ab = edge_value(tri_regs.vert_a_x, tri_regs.vert_a_y,
                          tri_regs.vert_b_x, tri_regs.vert_b_y, px, py);
        e_bc = edge_value(tri_regs.vert_b_x, tri_regs.vert_b_y,
                          tri_regs.vert_c_x, tri_regs.vert_c_y, px, py);
        e_ca = edge_value(tri_regs.vert_c_x, tri_regs.vert_c_y,
                          tri_regs.vert_a_x, tri_regs.vert_a_y, px, py);
        p.x       = walk_x;
        p.y       = walk_y;
        p.covered = e_ab >= 0 && e_bc >= 0 && e_ca >= 0;
        p.color   = p.covered ? tri_regs.fill_color : '0;
        p.last    = walk_x == maxx && walk_y == maxy;
        return p;
    endfunction

    // Step request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ch.valid   <= 1'b0;
            step_ch.restart <= 1'b0;
        end
        else
        begin
            if (step_ch.valid && step_ch.ready)
            begin
                expected_pixels.push_back(predict_pixel(step_ch.restart));
            end
            if (!step_ch.valid || step_ch.ready)
            begin
                if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    step_ch.valid   <= 1'b1;
                    step_ch.restart <= pending_steps.pop_front();
                end
                else
                begin
                    step_ch.valid   <= 1'b0;
                    step_ch.restart <= 1'($urandom_range(1));
                end
            end
        end
    end

    // Pixel result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            pixel_ch.ready <= 1'b0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_failure($sformatf("pixel (%0d,%0d) with no request pending",
                                             pixel_ch.pix_x, pixel_ch.pix_y));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_ch.pix_x !== want.x)
                        report_failure($sformatf("pix_x %0d, want %0d",
                                                 pixel_ch.pix_x, want.x));
                    if (pixel_ch.pix_y !== want.y)
                        report_failure($sformatf("pix_y %0d, want %0d",
                                                 pixel_ch.pix_y, want.y));
                    if (pixel_ch.covered !== want.covered)
                        report_failure($sformatf("covered %b, want %b at (%0d,%0d)",
                                                 pixel_ch.covered, want.covered,
                                                 want.x, want.y));
                    if (pixel_ch.pix_color !== want.color)
                        report_failure($sformatf("pix_color %h, want %h at (%0d,%0d)",
                                                 pixel_ch.pix_color, want.color,
                                                 want.x, want.y));
                    if (pixel_ch.last !== want.last)
                        report_failure($sformatf("last %b, want %b at (%0d,%0d)",
                                                 pixel_ch.last, want.last,
                                                 want.x, want.y));
                end
            end
            pixel_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("edge_function_triangle_raster test failed");
            $finish;
        end
    end

    task automatic write_reg(input eftr_pkg::cfg_reg_t idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        case (idx)
            eftr_pkg::REG_VERT_A_X:   tri_regs.vert_a_x   = value[VERT_W-1:0];
            eftr_pkg::REG_VERT_A_Y:   tri_regs.vert_a_y   = value[VERT_W-1:0];
            eftr_pkg::REG_VERT_B_X:   tri_regs.vert_b_x   = value[VERT_W-1:0];
            eftr_pkg::REG_VERT_B_Y:   tri_regs.vert_b_y   = value[VERT_W-1:0];
            eftr_pkg::REG_VERT_C_X:   tri_regs.vert_c_x   = value[VERT_W-1:0];
            eftr_pkg::REG_VERT_C_Y:   tri_regs.vert_c_y   = value[VERT_W-1:0];
            eftr_pkg::REG_FILL_COLOR: tri_regs.fill_color = value;
            default: ;
        endcase
    endtask

    task automatic write_triangle(input logic [VERT_W-1:0] ax, input logic [VERT_W-1:0] ay,
                                  input logic [VERT_W-1:0] bx, input logic [VERT_W-1:0] by,
                                  input logic [VERT_W-1:0] cx, input logic [VERT_W-1:0] cy,
                                  input logic [COLOR_W-1:0] color);
        write_reg(eftr_pkg::REG_VERT_A_X, CFG_DATA_W'(ax));
        write_reg(eftr_pkg::REG_VERT_A_Y, CFG_DATA_W'(ay));
        write_reg(eftr_pkg::REG_VERT_B_X, CFG_DATA_W'(bx));
        write_reg(eftr_pkg::REG_VERT_B_Y, CFG_DATA_W'(by));
        write_reg(eftr_pkg::REG_VERT_C_X, CFG_DATA_W'(cx));
        write_reg(eftr_pkg::REG_VERT_C_Y, CFG_DATA_W'(cy));
        write_reg(eftr_pkg::REG_FILL_COLOR, color);
    endtask

    // Blocks until every queued request is sent and every pixel has come back.
    task automatic wait_drained();
        while (pending_steps.size() != 0 || step_ch.valid || expected_pixels.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Mostly advances along the walk, with an occasional restart.
    task automatic add_steps(input int count, input int restart_pct);
        for (int i = 0; i < count; i++)
        begin
            pending_steps.push_back($urandom_range(99) < restart_pct);
        end
    endtask

    // Small boxes keep walks short so that wraps and last pixels come often.
    task automatic load_random_triangle();
        logic [VERT_W-1:0] v[6];
        int unsigned       span, base_x, base_y;
        int                mode;
        mode = $urandom_range(9);
        if (mode == 0)
        begin
            foreach (v[i])
                v[i] = VERT_W'($urandom);
            write_triangle(v[0], v[1], v[2], v[3], v[4], v[5], $urandom);
        end
        else if (mode == 1)
        begin
            // Only the colour changes, so the walk carries on where it was.
            write_reg(eftr_pkg::REG_FILL_COLOR, $urandom);
        end
        else
        begin
            span = 16 * $urandom_range(0, 7) + $urandom_range(0, 15);
            case ($urandom_range(7))
                0:       base_x = 0;
                1:       base_x = 16'hFFFF - span;
                default: base_x = $urandom_range(0, 16'hFFFF - span);
            endcase
            case ($urandom_range(7))
                0:       base_y = 0;
                1:       base_y = 16'hFFFF - span;
                default: base_y = $urandom_range(0, 16'hFFFF - span);
            endcase
            for (int i = 0; i < 6; i += 2)
            begin
                v[i]   = VERT_W'(base_x + $urandom_range(0, span));
                v[i+1] = VERT_W'(base_y + $urandom_range(0, span));
            end
            write_triangle(v[0], v[1], v[2], v[3], v[4], v[5], $urandom);
        end
    endtask

    initial
    begin
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = eftr_pkg::REG_VERT_A_X;
        cfg_ch.data    = '0;
        tri_regs       = '0;
        walk_x         = '0;
        walk_y         = '0;
        walk_active    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Advance before any walk behaves as a restart; all-zero registers give a
        // degenerate one-pixel box, which counts as covered.
        pending_steps = '{1'b0, 1'b0, 1'b1};
        wait_drained();

        // A 3x3 box walked past its end so that it wraps, then the opposite winding.
        write_triangle(16'd16, 16'd16, 16'd48, 16'd16, 16'd16, 16'd48, 32'hFFFF_FFFF);
        pending_steps.push_back(1'b1);
        add_steps(10, 0);
        wait_drained();
        write_triangle(16'd16, 16'd16, 16'd16, 16'd48, 16'd48, 16'd16, 32'h5A5A_A5A5);
        pending_steps.push_back(1'b1);
        add_steps(4, 0);
        wait_drained();

        // Far corner of the screen; the old position lies outside the new box.
        write_triangle(16'hFFFF, 16'hFFFF, 16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hFFF0, '0);
        add_steps(2, 0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int t = 0; t < 4; t++)
            begin
                load_random_triangle();
                add_steps($urandom_range(20, 40), 5);
                if (t == 1)
                begin
                    // Let the block go idle in mid walk, then carry on.
                    wait_drained();
                    add_steps($urandom_range(5, 10), 5);
                end
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("edge_function_triangle_raster test passed");
        end
        else
        begin
            $display("edge_function_triangle_raster test failed");
        end
        $finish;
    end

endmodule
